// File: hdl/ufdc_pkg.sv
// ---------------------------------------------------------------------------
// ufdc_pkg: shared types and constants
// Command, status and data-kind codes, the decoded operation type, the
// configuration bundle and the queue entry of the UART FIFO block.
// ---------------------------------------------------------------------------
`default_nettype none

package ufdc_pkg;

  localparam int CMD_W    = 3;
  localparam int BYTE_W   = 8;
  localparam int SEL_W    = 2;
  localparam int STATUS_W = 2;
  localparam int KIND_W   = 2;
  localparam int CNT_W    = 32;
  localparam int APB_W    = 32;
  localparam int ADDR_W   = 5;
  localparam int REG_IDX_W = 3;

  // Command codes as they arrive on the input channel.
  localparam logic [CMD_W-1:0] CMD_WRITE    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RX       = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TX_EMPTY = 3'd3;
  localparam logic [CMD_W-1:0] CMD_TX_DONE  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_QUERY    = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_REFUSED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_WAIT    = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_TX   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  // Error counter selects, also the indexes of the counter array.
  localparam logic [SEL_W-1:0] SEL_OVERRUN = 2'd0;
  localparam logic [SEL_W-1:0] SEL_NOISE   = 2'd1;
  localparam logic [SEL_W-1:0] SEL_FRAMING = 2'd2;
  // Select with no counter behind it; a query with it reads zero.
  localparam logic [SEL_W-1:0] SEL_NONE    = 2'd3;
  localparam int               NUM_ERR_CNT = 3;

  // Register indexes (byte address / 4).
  localparam logic [REG_IDX_W-1:0] REG_CTRL_D_HALT    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_DE_PIN_PRESENT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_DE_INVERT      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_RE_PIN_PRESENT = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RE_INVERT      = 3'd4;

  localparam logic [BYTE_W-1:0] CTRL_D = 8'd4;

  localparam int QDEPTH = 2;
  localparam int QAW    = 1;
  localparam int QCW    = 2;

  typedef enum logic [2:0] {
    OP_WRITE,
    OP_READ,
    OP_RX,
    OP_TX_EMPTY,
    OP_TX_DONE,
    OP_QUERY,
    OP_NONE
  } op_t;

  typedef struct packed {
    logic ctrl_d_halt;
    logic de_pin_present;
    logic de_invert;
    logic re_pin_present;
    logic re_invert;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [BYTE_W-1:0] data;
    logic             no_wait;
    logic             framing_err;
    logic             noise_err;
    logic             overrun_err;
    logic [SEL_W-1:0] counter_select;
    logic             is_ctrl_d;
  } item_t;

endpackage

`default_nettype wire

// File: hdl/ufdc_if.sv
// ---------------------------------------------------------------------------
// ufdc_if: channel interfaces
// Valid/ready channels for command words entering the block and result
// words leaving it.
// ---------------------------------------------------------------------------
`default_nettype none

interface ufdc_cmd_if;
  logic                         valid;
  logic                         ready;
  logic [ufdc_pkg::CMD_W-1:0]   command;
  logic [ufdc_pkg::BYTE_W-1:0]  data_in;
  logic                         no_wait;
  logic                         framing_err;
  logic                         noise_err;
  logic                         overrun_err;
  logic [ufdc_pkg::SEL_W-1:0]   counter_select;

  modport source (
    output valid, command, data_in, no_wait, framing_err, noise_err, overrun_err,
           counter_select,
    input  ready
  );
  modport sink (
    input  valid, command, data_in, no_wait, framing_err, noise_err, overrun_err,
           counter_select,
    output ready
  );
endinterface

interface ufdc_res_if;
  logic                          valid;
  logic                          ready;
  logic [ufdc_pkg::STATUS_W-1:0] status;
  logic [ufdc_pkg::KIND_W-1:0]   data_kind;
  logic [ufdc_pkg::BYTE_W-1:0]   data_out;
  logic                          de_level;
  logic                          re_level;
  logic                          txe_irq_enable;
  logic                          tc_irq_enable;
  logic                          wake_writer;
  logic                          wake_reader;
  logic                          halt;
  logic [ufdc_pkg::CNT_W-1:0]    counter_value;

  modport source (
    output valid, status, data_kind, data_out, de_level, re_level, txe_irq_enable,
           tc_irq_enable, wake_writer, wake_reader, halt, counter_value,
    input  ready
  );
  modport sink (
    input  valid, status, data_kind, data_out, de_level, re_level, txe_irq_enable,
           tc_irq_enable, wake_writer, wake_reader, halt, counter_value,
    output ready
  );
endinterface

`default_nettype wire

// File: hdl/uart_fifo_direction_control.sv
// ---------------------------------------------------------------------------
// uart_fifo_direction_control: UART byte buffer with RS-485 direction control
// Transmit and receive byte FIFOs, transmitter busy and driver-enable
// tracking, error counters and an APB register port for the pin options.
// ---------------------------------------------------------------------------
// Command words enter on the cmd channel and each produces exactly one
// result word on the res channel, in order. The intake stage classifies a
// word and places it in a two-entry queue, so cmd keeps being accepted
// until the queue is full while the execution stage works or waits on a
// stalled res channel. The execution stage has two steps per word: an idle
// step in which the FIFO memories are read at their current read index (the
// read data is registered), and an execute step in which the operation
// updates the FIFO indexes, flags and counters and loads the result
// register. It takes a new word from the queue only once it is back in the
// idle step, so words do not overlap in execution.
// The result register holds one word while the next word executes up to
// the point of loading it. The pin option registers sit at byte addresses
// 0 (control-D halt), 4 (driver pin present), 8 (driver pin inverted),
// 12 (receiver pin present) and 16 (receiver pin inverted); each holds bit 0
// of the written data and should only be changed while no word is in
// flight. No clearing pass is needed after reset: FIFO entries are only read
// once written.
// ---------------------------------------------------------------------------
`default_nettype none

module uart_fifo_direction_control #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  ufdc_cmd_if.sink                           cmd,
  ufdc_res_if.source                         res,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ufdc_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [ufdc_pkg::APB_W-1:0]    pwdata,
  output logic      [ufdc_pkg::APB_W-1:0]    prdata,
  output logic                               pready
);

  ufdc_pkg::cfg_t  cfg;
  ufdc_pkg::item_t push_item;
  ufdc_pkg::item_t pop_item;
  logic            push_valid;
  logic            push_ready;
  logic            pop_valid;
  logic            pop_ready;
  logic [ufdc_pkg::REG_IDX_W-1:0] reg_idx;
  logic            reg_bit;

  // Registers are word spaced; the two low address bits are not decoded.
  assign reg_idx = paddr[ufdc_pkg::ADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        ufdc_pkg::REG_CTRL_D_HALT:    cfg.ctrl_d_halt    <= pwdata[0];
        ufdc_pkg::REG_DE_PIN_PRESENT: cfg.de_pin_present <= pwdata[0];
        ufdc_pkg::REG_DE_INVERT:      cfg.de_invert      <= pwdata[0];
        ufdc_pkg::REG_RE_PIN_PRESENT: cfg.re_pin_present <= pwdata[0];
        ufdc_pkg::REG_RE_INVERT:      cfg.re_invert      <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      ufdc_pkg::REG_CTRL_D_HALT:    reg_bit = cfg.ctrl_d_halt;
      ufdc_pkg::REG_DE_PIN_PRESENT: reg_bit = cfg.de_pin_present;
      ufdc_pkg::REG_DE_INVERT:      reg_bit = cfg.de_invert;
      ufdc_pkg::REG_RE_PIN_PRESENT: reg_bit = cfg.re_pin_present;
      ufdc_pkg::REG_RE_INVERT:      reg_bit = cfg.re_invert;
      default:                      reg_bit = 1'b0;
    endcase
    prdata = {{(ufdc_pkg::APB_W-1){1'b0}}, reg_bit};
  end

  ufdc_front u_front (
    .cmd        (cmd),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  ufdc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  ufdc_back #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_valid (pop_valid),
    .q_item  (pop_item),
    .q_ready (pop_ready),
    .res     (res)
  );

endmodule

`default_nettype wire

// File: hdl/ufdc_front.sv
// ---------------------------------------------------------------------------
// ufdc_front: command intake
// Accepts command words and classifies them into operations for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module ufdc_front (
  ufdc_cmd_if.sink        cmd,
  output logic            push_valid,
  output ufdc_pkg::item_t push_item,
  input  wire logic       push_ready
);

  ufdc_pkg::op_t op;

  always_comb begin
    case (cmd.command)
      ufdc_pkg::CMD_WRITE:    op = ufdc_pkg::OP_WRITE;
      ufdc_pkg::CMD_READ:     op = ufdc_pkg::OP_READ;
      ufdc_pkg::CMD_RX:       op = ufdc_pkg::OP_RX;
      ufdc_pkg::CMD_TX_EMPTY: op = ufdc_pkg::OP_TX_EMPTY;
      ufdc_pkg::CMD_TX_DONE:  op = ufdc_pkg::OP_TX_DONE;
      ufdc_pkg::CMD_QUERY:    op = ufdc_pkg::OP_QUERY;
      default:                op = ufdc_pkg::OP_NONE;
    endcase
  end

  always_comb begin
    push_item.op             = op;
    push_item.data           = cmd.data_in;
    push_item.no_wait        = cmd.no_wait;
    push_item.framing_err    = cmd.framing_err;
    push_item.noise_err      = cmd.noise_err;
    push_item.overrun_err    = cmd.overrun_err;
    push_item.counter_select = cmd.counter_select;
    // Control-D is flagged here so the back end only has to test one bit.
    push_item.is_ctrl_d      = (cmd.data_in == ufdc_pkg::CTRL_D);
  end

  assign push_valid = cmd.valid;
  assign cmd.ready  = push_ready;

endmodule

`default_nettype wire

// File: hdl/ufdc_queue.sv
// ---------------------------------------------------------------------------
// ufdc_queue: operation queue
// Two-entry FIFO of classified operations between intake and execution.
// ---------------------------------------------------------------------------
`default_nettype none

module ufdc_queue (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push_valid,
  input  ufdc_pkg::item_t push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output ufdc_pkg::item_t pop_item,
  input  wire logic       pop_ready
);

  ufdc_pkg::item_t              entries [ufdc_pkg::QDEPTH];
  logic [ufdc_pkg::QAW-1:0]     wr_ptr;
  logic [ufdc_pkg::QAW-1:0]     rd_ptr;
  logic [ufdc_pkg::QCW-1:0]     count;
  logic                         do_push;
  logic                         do_pop;

  assign push_ready = (count != ufdc_pkg::QCW'(ufdc_pkg::QDEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + ufdc_pkg::QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + ufdc_pkg::QAW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + ufdc_pkg::QCW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - ufdc_pkg::QCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: hdl/ufdc_back.sv
// ---------------------------------------------------------------------------
// ufdc_back: operation execution
// Owns both byte FIFOs, the transmitter and direction flags and the error
// counters, and registers one result word per operation.
// ---------------------------------------------------------------------------
`default_nettype none

module ufdc_back #(
  parameter int TX_DEPTH = 64,
  parameter int RX_DEPTH = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  ufdc_pkg::cfg_t  cfg,
  input  wire logic       q_valid,
  input  ufdc_pkg::item_t q_item,
  output logic            q_ready,
  ufdc_res_if.source      res
);

  localparam int TX_IW = $clog2(2 * TX_DEPTH);
  localparam int TX_SW = $clog2(TX_DEPTH);
  localparam int RX_IW = $clog2(2 * RX_DEPTH);
  localparam int RX_SW = $clog2(RX_DEPTH);
  // Writer wakes while more than three quarters of the FIFO is free.
  localparam int TX_WAKE_FREE = 3 * TX_DEPTH / 4;
  localparam int TX_WAKE_USED = TX_DEPTH - TX_WAKE_FREE;

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t state;
  ufdc_pkg::item_t cur;

  logic [ufdc_pkg::BYTE_W-1:0] tx_mem [TX_DEPTH];
  logic [ufdc_pkg::BYTE_W-1:0] rx_mem [RX_DEPTH];
  logic [ufdc_pkg::BYTE_W-1:0] tx_rd_data;
  logic [ufdc_pkg::BYTE_W-1:0] rx_rd_data;

  logic [TX_IW-1:0] tx_w, tx_r, tx_w_next, tx_r_next, tx_cnt;
  logic [RX_IW-1:0] rx_w, rx_r, rx_w_next, rx_r_next, rx_cnt;
  logic [TX_IW-1:0] tx_w_sum, tx_r_sum;
  logic [RX_IW-1:0] rx_w_sum, rx_r_sum;
  logic [TX_SW-1:0] tx_w_slot, tx_r_slot;
  logic [RX_SW-1:0] rx_w_slot, rx_r_slot;

  logic busy, busy_next;
  logic dir, dir_next;
  logic [ufdc_pkg::CNT_W-1:0] err_cnt [ufdc_pkg::NUM_ERR_CNT];

  logic fire;
  logic tx_we, rx_we, count_errs;
  logic [ufdc_pkg::STATUS_W-1:0] status;
  logic [ufdc_pkg::KIND_W-1:0]   kind;
  logic [ufdc_pkg::BYTE_W-1:0]   dout;
  logic [ufdc_pkg::CNT_W-1:0]    counter;
  logic wake_w, wake_r, halt;

  // Indexes run over twice the depth so that full and empty differ; the slot
  // folds the upper half back onto the memory.
  assign tx_w_sum  = tx_w - TX_IW'(TX_DEPTH);
  assign tx_r_sum  = tx_r - TX_IW'(TX_DEPTH);
  assign rx_w_sum  = rx_w - RX_IW'(RX_DEPTH);
  assign rx_r_sum  = rx_r - RX_IW'(RX_DEPTH);
  assign tx_w_slot = (tx_w >= TX_IW'(TX_DEPTH)) ? tx_w_sum[TX_SW-1:0] : tx_w[TX_SW-1:0];
  assign tx_r_slot = (tx_r >= TX_IW'(TX_DEPTH)) ? tx_r_sum[TX_SW-1:0] : tx_r[TX_SW-1:0];
  assign rx_w_slot = (rx_w >= RX_IW'(RX_DEPTH)) ? rx_w_sum[RX_SW-1:0] : rx_w[RX_SW-1:0];
  assign rx_r_slot = (rx_r >= RX_IW'(RX_DEPTH)) ? rx_r_sum[RX_SW-1:0] : rx_r[RX_SW-1:0];

  assign tx_cnt = (tx_w >= tx_r) ? tx_w - tx_r : tx_w - tx_r + TX_IW'(2 * TX_DEPTH);
  assign rx_cnt = (rx_w >= rx_r) ? rx_w - rx_r : rx_w - rx_r + RX_IW'(2 * RX_DEPTH);

  assign q_ready = (state == S_IDLE);
  assign fire    = (state == S_EXEC) && (!res.valid || res.ready);

  always_comb begin
    tx_w_next  = tx_w;
    tx_r_next  = tx_r;
    rx_w_next  = rx_w;
    rx_r_next  = rx_r;
    busy_next  = busy;
    dir_next   = dir;
    tx_we      = 1'b0;
    rx_we      = 1'b0;
    count_errs = 1'b0;
    status     = ufdc_pkg::STATUS_OK;
    kind       = ufdc_pkg::KIND_NONE;
    dout       = '0;
    counter    = '0;
    wake_w     = 1'b0;
    wake_r     = 1'b0;
    halt       = 1'b0;
    case (cur.op)
      ufdc_pkg::OP_WRITE: begin
        if (tx_cnt == TX_IW'(TX_DEPTH)) begin
          status = cur.no_wait ? ufdc_pkg::STATUS_REFUSED : ufdc_pkg::STATUS_WAIT;
        end else if (!busy) begin
          kind      = ufdc_pkg::KIND_TX;
          dout      = cur.data;
          busy_next = 1'b1;
          if (cfg.de_pin_present) begin
            dir_next = 1'b1;
          end
        end else begin
          tx_we     = 1'b1;
          tx_w_next = (tx_w == TX_IW'(2 * TX_DEPTH - 1)) ? '0 : tx_w + TX_IW'(1);
        end
      end
      ufdc_pkg::OP_READ: begin
        if (rx_cnt == '0) begin
          status = ufdc_pkg::STATUS_EMPTY;
        end else begin
          kind      = ufdc_pkg::KIND_READ;
          dout      = rx_rd_data;
          rx_r_next = (rx_r == RX_IW'(2 * RX_DEPTH - 1)) ? '0 : rx_r + RX_IW'(1);
        end
      end
      ufdc_pkg::OP_RX: begin
        if (cfg.ctrl_d_halt && cur.is_ctrl_d) begin
          halt = 1'b1;
        end else begin
          count_errs = 1'b1;
          if (rx_cnt != RX_IW'(RX_DEPTH)) begin
            rx_we     = 1'b1;
            wake_r    = 1'b1;
            rx_w_next = (rx_w == RX_IW'(2 * RX_DEPTH - 1)) ? '0 : rx_w + RX_IW'(1);
          end
        end
      end
      ufdc_pkg::OP_TX_EMPTY: begin
        if (tx_cnt == '0) begin
          busy_next = 1'b0;
        end else begin
          kind      = ufdc_pkg::KIND_TX;
          dout      = tx_rd_data;
          tx_r_next = (tx_r == TX_IW'(2 * TX_DEPTH - 1)) ? '0 : tx_r + TX_IW'(1);
          wake_w    = ((tx_cnt - TX_IW'(1)) < TX_IW'(TX_WAKE_USED));
        end
      end
      ufdc_pkg::OP_TX_DONE: begin
        if (cfg.de_pin_present) begin
          dir_next = 1'b0;
        end
      end
      ufdc_pkg::OP_QUERY: begin
        if (cur.counter_select != ufdc_pkg::SEL_NONE) begin
          counter = err_cnt[cur.counter_select];
        end
      end
      default: begin
      end
    endcase
  end

  // Read data is registered: the address is steady during the idle cycle, so
  // the execute cycle sees the entry at the current read index.
  always_ff @(posedge clk) begin
    tx_rd_data <= tx_mem[tx_r_slot];
    if (fire && tx_we) begin
      tx_mem[tx_w_slot] <= cur.data;
    end
  end

  always_ff @(posedge clk) begin
    rx_rd_data <= rx_mem[rx_r_slot];
    if (fire && rx_we) begin
      rx_mem[rx_w_slot] <= cur.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res.valid <= 1'b0;
      tx_w      <= '0;
      tx_r      <= '0;
      rx_w      <= '0;
      rx_r      <= '0;
      busy      <= 1'b0;
      dir       <= 1'b0;
      for (int i = 0; i < ufdc_pkg::NUM_ERR_CNT; i++) begin
        err_cnt[i] <= '0;
      end
    end else begin
      // A new result loads the register; otherwise an accepted one leaves it.
      if (fire) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur   <= q_item;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (fire) begin
            tx_w <= tx_w_next;
            tx_r <= tx_r_next;
            rx_w <= rx_w_next;
            rx_r <= rx_r_next;
            busy <= busy_next;
            dir  <= dir_next;
            if (count_errs && cur.overrun_err) begin
              err_cnt[ufdc_pkg::SEL_OVERRUN] <= err_cnt[ufdc_pkg::SEL_OVERRUN] + 32'd1;
            end
            if (count_errs && cur.noise_err) begin
              err_cnt[ufdc_pkg::SEL_NOISE] <= err_cnt[ufdc_pkg::SEL_NOISE] + 32'd1;
            end
            if (count_errs && cur.framing_err) begin
              err_cnt[ufdc_pkg::SEL_FRAMING] <= err_cnt[ufdc_pkg::SEL_FRAMING] + 32'd1;
            end
            res.status         <= status;
            res.data_kind      <= kind;
            res.data_out       <= dout;
            res.de_level       <= cfg.de_pin_present && (dir_next ^ cfg.de_invert);
            res.re_level       <= cfg.de_pin_present && cfg.re_pin_present &&
                                  (!dir_next ^ cfg.re_invert);
            res.txe_irq_enable <= busy_next;
            res.tc_irq_enable  <= dir_next;
            res.wake_writer    <= wake_w;
            res.wake_reader    <= wake_r;
            res.halt           <= halt;
            res.counter_value  <= counter;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
